// ===== src/msp_pkg.sv =====
// package for the minimum sum partition block
// shared constants and controller/datapath command and status types
package msp_pkg;
  localparam int unsigned MAX_TOTAL_DEF = 4095;
  localparam int unsigned VAL_W = 12;
  localparam int unsigned WORD_W = 64;

  typedef struct packed {
    logic clr_start;
    logic load;
    logic shift_start;
    logic search_start;
  } msp_cmd_t;

  typedef struct packed {
    logic busy;
    logic done;
    logic skip;
  } msp_sts_t;
endpackage

// ===== src/msp_datapath.sv =====
// datapath: reachable-sum memory, shift-or sweep, clear sweep and result search
// depends on msp_pkg
module msp_datapath import msp_pkg::*; #(
  parameter int unsigned MAX_TOTAL = MAX_TOTAL_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  msp_cmd_t         cmd,
  output msp_sts_t         sts,
  input  logic [VAL_W-1:0] in_value,
  input  logic             in_last,
  output logic [VAL_W-1:0] min_diff,
  output logic             ovf,
  output logic             last_r
);
  localparam int unsigned NWORDS = MAX_TOTAL / WORD_W + 1;
  localparam int unsigned AW = (NWORDS > 1) ? $clog2(NWORDS) : 1;
  localparam int unsigned TW = $clog2(MAX_TOTAL + 1) + 1;
  localparam int unsigned BW = $clog2(WORD_W);

  typedef enum logic [2:0] {
    M_IDLE, M_CLR, M_RD, M_SHIFT, M_SRCH
  } mode_t;

  logic [WORD_W-1:0] mem [NWORDS];
  logic [AW:0] i_r, i_nxt;
  logic [AW:0] j_r, j_nxt;
  mode_t mode_r, mode_nxt;
  logic [VAL_W-1:0] v_r;
  logic [TW-1:0] tot_r, tot_nxt;
  logic ovf_r, ovf_nxt;
  logic last_q;
  logic [WORD_W-1:0] rd_hi_r, rd_lo_r, prev_hi;
  logic [TW-1:0] half;
  logic [VAL_W-1:0] diff_r, diff_nxt;
  logic done_r, done_nxt;
  logic [TW:0] sum;
  logic [VAL_W-1:0] ws_full;
  logic [BW-1:0] bs;
  logic [WORD_W-1:0] part, cand;
  logic we;
  logic [AW-1:0] waddr;
  logic [WORD_W-1:0] wdata;
  logic [AW:0] rd_hi_a, rd_lo_a;
  logic [AW:0] rd_q_a;
  logic rd_q_zero;
  logic skip;
  logic [TW-1:0] hw;
  logic [BW-1:0] hb;
  logic found;
  logic [BW-1:0] fpos;

  assign sum = {1'b0, tot_r} + (TW+1)'(in_value);
  assign ws_full = v_r >> BW;
  assign bs = v_r[BW-1:0];
  assign half = tot_r >> 1;
  assign hw = half >> BW;
  assign hb = half[BW-1:0];
  assign rd_hi_a = i_r - (AW+1)'(ws_full);
  assign rd_lo_a = rd_hi_a - 1'b1;
  // top source word is fetched while idle, then one lower source word per word
  assign rd_q_a = (mode_r == M_IDLE) ? (AW+1)'(NWORDS - 1) - (AW+1)'(ws_full) : rd_lo_a;
  assign rd_q_zero = (mode_r != M_IDLE) && (rd_hi_a == '0);

  always_ff @(posedge clk) begin
    if (mode_r == M_RD) begin
      rd_hi_r <= rd_lo_r;
    end
    rd_lo_r <= rd_q_zero ? '0 : mem[rd_q_a[AW-1:0]];
    prev_hi <= mem[i_r[AW-1:0]];
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_comb begin
    part = rd_hi_r << bs;
    if (bs != '0) begin
      part = part | (rd_lo_r >> (BW+1)'(WORD_W - int'(bs)));
    end
    cand = prev_hi;
    if (j_r[AW-1:0] == hw[AW-1:0]) begin
      cand = prev_hi & ((WORD_W'(2) << hb) - 1'b1);
    end
    found = 1'b0;
    fpos = '0;
    for (int k = 0; k < WORD_W; k++) begin
      if (cand[k]) begin
        found = 1'b1;
        fpos = BW'(k);
      end
    end
  end

  always_comb begin
    mode_nxt = mode_r;
    i_nxt = i_r;
    j_nxt = j_r;
    tot_nxt = tot_r;
    ovf_nxt = ovf_r;
    diff_nxt = diff_r;
    done_nxt = 1'b0;
    we = 1'b0;
    waddr = i_r[AW-1:0];
    wdata = '0;
    skip = 1'b0;
    unique case (mode_r)
      M_IDLE: begin
        if (cmd.clr_start) begin
          mode_nxt = M_CLR;
          i_nxt = '0;
        end else if (cmd.load) begin
          if (!ovf_r) begin
            if (sum > (TW+1)'(MAX_TOTAL)) begin
              ovf_nxt = 1'b1;
              skip = 1'b1;
            end else if (in_value == '0 || (VAL_W'(in_value >> BW) >= VAL_W'(NWORDS))) begin
              tot_nxt = sum[TW-1:0];
              skip = 1'b1;
            end else begin
              tot_nxt = sum[TW-1:0];
            end
          end else begin
            skip = 1'b1;
          end
        end else if (cmd.shift_start) begin
          mode_nxt = M_RD;
          i_nxt = (AW+1)'(NWORDS - 1);
        end else if (cmd.search_start) begin
          if (ovf_r) begin
            diff_nxt = '0;
            done_nxt = 1'b1;
          end else begin
            mode_nxt = M_SRCH;
            i_nxt = hw[AW:0];
            j_nxt = hw[AW:0] + 1'b1;
          end
        end
      end
      M_CLR: begin
        we = 1'b1;
        wdata = (i_r == '0) ? WORD_W'(1) : '0;
        if (i_r == (AW+1)'(NWORDS - 1)) begin
          mode_nxt = M_IDLE;
          tot_nxt = '0;
          ovf_nxt = 1'b0;
          done_nxt = 1'b1;
        end
        i_nxt = i_r + 1'b1;
      end
      M_RD: begin
        mode_nxt = M_SHIFT;
        j_nxt = i_r;
      end
      M_SHIFT: begin
        we = 1'b1;
        waddr = j_r[AW-1:0];
        wdata = prev_hi | part;
        if (j_r == (AW+1)'(ws_full)) begin
          mode_nxt = M_IDLE;
          done_nxt = 1'b1;
        end else begin
          i_nxt = j_r - 1'b1;
          mode_nxt = M_RD;
        end
      end
      M_SRCH: begin
        if (i_r != j_r) begin
          j_nxt = i_r;
        end else if (found) begin
          diff_nxt = VAL_W'(tot_r - (TW'({j_r[AW-1:0], fpos}) << 1));
          mode_nxt = M_IDLE;
          done_nxt = 1'b1;
        end else begin
          i_nxt = j_r - 1'b1;
        end
      end
      default: mode_nxt = M_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= M_CLR;
      i_r <= '0;
      j_r <= '0;
      tot_r <= '0;
      ovf_r <= 1'b0;
      done_r <= 1'b0;
      last_q <= 1'b0;
    end else begin
      mode_r <= mode_nxt;
      i_r <= i_nxt;
      j_r <= j_nxt;
      tot_r <= tot_nxt;
      ovf_r <= ovf_nxt;
      done_r <= done_nxt;
      if (cmd.load) begin
        last_q <= in_last;
      end
    end
    diff_r <= diff_nxt;
    if (cmd.load) begin
      v_r <= in_value;
    end
  end

  assign sts.busy = (mode_r != M_IDLE);
  assign sts.done = done_r;
  assign sts.skip = skip;
  assign min_diff = diff_r;
  assign ovf = ovf_r;
  assign last_r = last_q;
endmodule

// ===== src/msp_ctrl.sv =====
// controller: sequences load, shift-or, search, result and clear
// depends on msp_pkg
module msp_ctrl import msp_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_tvalid,
  output logic     in_tready,
  output logic     out_tvalid,
  input  logic     out_tready,
  output msp_cmd_t cmd,
  input  msp_sts_t sts,
  input  logic     last_r,
  input  logic     dp_ovf,
  input  logic [VAL_W-1:0] dp_diff,
  output logic [VAL_W-1:0] res_diff,
  output logic     res_ovf
);
  typedef enum logic [2:0] {
    S_CLR, S_IDLE, S_SHIFT, S_NEXT, S_SRCH, S_OUT, S_WCLR
  } state_t;

  state_t state_r, state_nxt;
  logic loaded;
  logic skip_r;

  assign in_tready = (state_r == S_IDLE) && !out_tvalid;
  assign loaded = in_tvalid && in_tready;

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    unique case (state_r)
      S_CLR: if (sts.done) state_nxt = S_IDLE;
      S_IDLE: begin
        if (loaded) begin
          cmd.load = 1'b1;
          state_nxt = S_SHIFT;
        end
      end
      S_SHIFT: begin
        state_nxt = S_NEXT;
      end
      S_NEXT: begin
        if (!sts.busy) begin
          state_nxt = last_r ? S_SRCH : S_IDLE;
          if (last_r) cmd.search_start = 1'b1;
        end
      end
      S_SRCH: if (sts.done) state_nxt = S_OUT;
      S_OUT: begin
        cmd.clr_start = 1'b1;
        state_nxt = S_WCLR;
      end
      S_WCLR: if (sts.done) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
    if (state_r == S_SHIFT && !skip_r) cmd.shift_start = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
      out_tvalid <= 1'b0;
      skip_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cmd.load) skip_r <= sts.skip;
      if (state_r == S_SRCH && sts.done) begin
        out_tvalid <= 1'b1;
        res_diff <= dp_ovf ? '0 : dp_diff;
        res_ovf <= dp_ovf;
      end else if (out_tvalid && out_tready) begin
        out_tvalid <= 1'b0;
      end
    end
  end
endmodule

// ===== src/min_sum_partition_difference.sv =====
// Minimum sum partition block. Values stream in one per request; tlast closes a set and
// one result follows. Each nonzero value that keeps the total within MAX_TOTAL sweeps the
// reachable-sum memory from the top word down, with a read state and a shift state per
// word. The closing search walks words down from total/2, then a clear sweep runs after
// each result and after reset.
// depends on msp_pkg, msp_ctrl, msp_datapath
module min_sum_partition_difference import msp_pkg::*; #(
  parameter int unsigned MAX_TOTAL = MAX_TOTAL_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // value[11:0]
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // min_diff[11:0]
  output logic        out_tuser   // overflow
);
  msp_cmd_t cmd;
  msp_sts_t sts;
  logic [VAL_W-1:0] dp_diff, res_diff;
  logic dp_ovf, res_ovf, last_r;

  msp_ctrl u_ctrl (
    .clk, .rst_n, .in_tvalid, .in_tready, .out_tvalid, .out_tready,
    .cmd, .sts, .last_r, .dp_ovf, .dp_diff, .res_diff, .res_ovf
  );

  msp_datapath #(.MAX_TOTAL(MAX_TOTAL)) u_dp (
    .clk, .rst_n, .cmd, .sts,
    .in_value(in_tdata[VAL_W-1:0]), .in_last(in_tlast),
    .min_diff(dp_diff), .ovf(dp_ovf), .last_r
  );

  assign out_tdata = {4'b0, res_diff};
  assign out_tuser = res_ovf;
endmodule

// ===== src/msp_checker.sv =====
// port-level checker for the minimum sum partition block, bound to the top level
// depends on min_sum_partition_difference
module msp_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [15:0] out_tdata,
  input logic        out_tuser
);
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result dropped while stalled");
  a_ovf_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata == 16'd0)
    else $error("overflow result not zero");
  a_no_take: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !in_tready)
    else $error("request taken with result pending");
  a_pad: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[15:12] == 4'd0)
    else $error("pad bits set");
endmodule

bind min_sum_partition_difference msp_checker u_chk (
  .clk, .rst_n, .in_tvalid, .in_tready, .out_tvalid, .out_tready, .out_tdata, .out_tuser
);

// ===== tb/min_sum_partition_difference_tb.sv =====
// testbench for min_sum_partition_difference: streams value sets, predicts each set's
// minimum partition difference with a bitset model and checks every result in order
// depends on msp_pkg and the min_sum_partition_difference rtl
module min_sum_partition_difference_tb;
  import msp_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned NUM_WORDS = MAX_TOTAL_DEF / 64 + 1;
  localparam int unsigned SUM_BITS = NUM_WORDS * 64;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES = 400;

  typedef struct packed {
    logic [VAL_W-1:0] value;
    logic             last;
  } elem_t;

  typedef struct packed {
    logic [VAL_W-1:0] min_diff;
    logic             overflow;
  } part_res_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [15:0] in_tdata;
  logic        in_tlast;
  logic        out_tvalid;
  logic        out_tready;
  logic [15:0] out_tdata;
  logic        out_tuser;

  elem_t     elem_q[$];
  part_res_t diff_q[$];
  logic [SUM_BITS-1:0] reach_set;
  int unsigned sum_total;
  bit          sum_ovf;
  int          fail_cnt = 0;
  int          idle_cycles;
  bit          feed_on;
  bit          hold_rx;
  bit          pause_tx;
  int          burst_left;
  int          gap_left;
  int          rx_phase;
  logic        in_tready_s;

  min_sum_partition_difference dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tlast(in_tlast),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser)
  );

  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  function automatic void clear_sums();
    reach_set = '0;
    reach_set[0] = 1'b1;
    sum_total = 0;
    sum_ovf = 1'b0;
  endfunction

  function automatic void predict_partition(elem_t e);
    part_res_t r;
    int unsigned s;
    if (!sum_ovf) begin
      if (sum_total + e.value > MAX_TOTAL_DEF) begin
        sum_ovf = 1'b1;
      end else begin
        sum_total += e.value;
        reach_set = reach_set | (reach_set << e.value);
      end
    end
    if (e.last) begin
      if (sum_ovf) begin
        r.min_diff = '0;
        r.overflow = 1'b1;
      end else begin
        s = sum_total / 2;
        while (s > 0 && !reach_set[s]) s--;
        r.min_diff = VAL_W'(sum_total - 2 * s);
        r.overflow = 1'b0;
      end
      diff_q.insert(diff_q.size(), r);
      clear_sums();
    end
  endfunction

  task automatic add_elem(int unsigned v, bit l);
    elem_t e;
    e.value = VAL_W'(v);
    e.last = l;
    elem_q.insert(elem_q.size(), e);
  endtask

  task automatic add_set(int n, int unsigned vmax);
    for (int i = 0; i < n; i++) add_elem($urandom_range(0, vmax), i == n - 1);
  endtask

  // sender: bursts and gaps, stops when paused
  always @(negedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata <= '0;
      in_tlast <= 1'b0;
      burst_left <= 0;
      gap_left <= 0;
    end else if (!(in_tvalid && !in_tready_s)) begin
      if (feed_on && !pause_tx && elem_q.size() > 0 && gap_left == 0) begin
        in_tvalid <= 1'b1;
        in_tdata <= {4'b0, elem_q[0].value};
        in_tlast <= elem_q[0].last;
        if (burst_left == 0) begin
          burst_left <= $urandom_range(1, 30);
          gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 80);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        in_tvalid <= 1'b0;
        if (gap_left > 0) gap_left <= gap_left - 1;
      end
    end
  end

  // accepted flag for the driver, taken at the rising edge
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tready_s <= 1'b0;
    end else begin
      in_tready_s <= 1'b0;
      if (in_tvalid && in_tready) begin
        predict_partition(elem_q.pop_front());
        in_tready_s <= 1'b1;
      end
    end
  end

  // receiver stall pattern
  always @(negedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      rx_phase <= 0;
    end else begin
      rx_phase <= rx_phase + 1;
      if (hold_rx) out_tready <= 1'b0;
      else if (rx_phase % 512 < 200) out_tready <= 1'b1;
      else out_tready <= ($urandom_range(0, 3) != 0);
    end
  end

  // result monitor and watchdog
  always @(posedge clk) begin
    part_res_t got;
    part_res_t want;
    if (!rst_n) begin
      idle_cycles <= 0;
    end else begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (out_tvalid && out_tready) begin
        got.min_diff = out_tdata[VAL_W-1:0];
        got.overflow = out_tuser;
        if (diff_q.size() == 0) begin
          $display("%0t: unexpected result min_diff=%0d overflow=%0b", $time,
                   got.min_diff, got.overflow);
          fail_cnt++;
        end else begin
          want = diff_q.pop_front();
          if (got.min_diff !== want.min_diff) begin
            $display("%0t: min_diff expected %0d actual %0d", $time, want.min_diff,
                     got.min_diff);
            fail_cnt++;
          end
          if (got.overflow !== want.overflow) begin
            $display("%0t: overflow expected %0b actual %0b", $time, want.overflow,
                     got.overflow);
            fail_cnt++;
          end
        end
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  initial begin
    int n;
    int kind;
    int cnt;
    rst_n = 1'b0;
    feed_on = 1'b0;
    hold_rx = 1'b0;
    pause_tx = 1'b0;
    clear_sums();
    // directed sets
    add_elem(0, 1);
    add_elem(4095, 1);
    add_elem(1, 0); add_elem(2, 0); add_elem(3, 1);
    add_elem(0, 0); add_elem(7, 0); add_elem(0, 1);
    add_elem(2048, 0); add_elem(2047, 1);
    add_elem(4095, 0); add_elem(1, 0); add_elem(5, 1);
    add_elem(3000, 0); add_elem(3000, 0); add_elem(10, 1);
    add_elem(64, 0); add_elem(63, 0); add_elem(65, 0); add_elem(128, 1);
    add_elem(1365, 0); add_elem(2730, 1);
    add_elem(4094, 0); add_elem(1, 1);
    cnt = elem_q.size();
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    feed_on = 1'b1;
    while (cnt < 850) begin
      kind = $urandom_range(0, 9);
      n = $urandom_range(1, 12);
      if (kind < 5) add_set(n, 255);
      else if (kind < 7) add_set(n, 1023);
      else if (kind < 9) add_set(n, 4095);
      else add_set(n, 15);
      cnt += n;
      if (cnt > 300 && cnt < 320) begin
        while (elem_q.size() > 0) @(posedge clk);
        // long receiver hold while items keep coming
        hold_rx = 1'b1;
        add_set(8, 40); add_set(8, 40); add_set(8, 40); add_set(8, 40);
        cnt += 32;
        repeat (3000) @(posedge clk);
        hold_rx = 1'b0;
        while (elem_q.size() > 0) @(posedge clk);
        pause_tx = 1'b1;
        while (diff_q.size() > 0) @(posedge clk);
        pause_tx = 1'b0;
      end
    end
    while (elem_q.size() > 0 || diff_q.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_cnt == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule

// ===== min_sum_partition_difference.f =====
src/msp_pkg.sv
src/msp_datapath.sv
src/msp_ctrl.sv
src/min_sum_partition_difference.sv
src/msp_checker.sv
tb/min_sum_partition_difference_tb.sv
